>>> hw/rtl/wals_pkg.sv
// wals_pkg: shared types, codes and constants of the antialiased line stepper
// used by every module of the stepper; no dependencies
`default_nettype none

package wals_pkg;

  // internal widths, sized for the whole screen and fraction range
  localparam int CW    = 20;  // clipped coordinate, signed
  localparam int DVW   = 52;  // divider dividend and quotient
  localparam int DSW   = 21;  // divider divisor
  localparam int YW    = 56;  // minor position accumulator, signed
  localparam int FW    = 32;  // slope and minor fraction bits
  localparam int IDXW  = 16;  // framebuffer index
  localparam int CHW   = 8;   // channel addend
  localparam int GAINW = 9;   // channel gain
  localparam int CIDXW = 2;   // config register index
  localparam int STEPW = 11;  // remaining pairs

  // input operation codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // result status codes
  localparam logic [1:0] STAT_ACCEPTED = 2'd0;
  localparam logic [1:0] STAT_REJECTED = 2'd1;
  localparam logic [1:0] STAT_PAIR     = 2'd2;
  localparam logic [1:0] STAT_IDLE     = 2'd3;

  // config register indexes
  localparam logic [CIDXW-1:0] REG_GAIN_RED   = 2'd0;
  localparam logic [CIDXW-1:0] REG_GAIN_GREEN = 2'd1;
  localparam logic [CIDXW-1:0] REG_GAIN_BLUE  = 2'd2;

  localparam logic [GAINW-1:0] GAIN_RESET = 9'd256;

  typedef struct packed {
    logic               op;
    logic signed [15:0] x_start;
    logic signed [15:0] y_start;
    logic signed [15:0] x_end;
    logic signed [15:0] y_end;
  } in_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [IDXW-1:0] near_index;
    logic [CHW-1:0]  near_red;
    logic [CHW-1:0]  near_green;
    logic [CHW-1:0]  near_blue;
    logic [IDXW-1:0] far_index;
    logic [CHW-1:0]  far_red;
    logic [CHW-1:0]  far_green;
    logic [CHW-1:0]  far_blue;
    logic            last_pair;
  } out_t;

  // datapath commands
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_STEP,
    CMD_CLIP_MUL,
    CMD_DIV_CLIP,
    CMD_CLIP_STORE,
    CMD_CLIP_APPLY,
    CMD_ORIENT,
    CMD_SLOPE_ZERO,
    CMD_DIV_SLOPE,
    CMD_SLOPE_STORE,
    CMD_INIT,
    CMD_YMUL,
    CMD_SEARCH_STEP,
    CMD_FINISH,
    CMD_REJECT
  } cmd_e;

  typedef struct packed {
    cmd_e op;
    logic axis_y;  // clip stage works on y
    logic second;  // second endpoint of the clip stage
  } cmd_t;

  typedef struct packed {
    logic reject;
    logic clip_needed;
    logic div_done;
    logic du_zero;
    logic visible;
    logic n_zero;
    logic out_free;
  } stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_MUL,
    S_DIV_GO,
    S_DIV_WAIT,
    S_STORE,
    S_APPLY,
    S_ORIENT,
    S_SLOPE_GO,
    S_SLOPE_WAIT,
    S_SLOPE_STORE,
    S_INIT,
    S_YMUL,
    S_SEARCH,
    S_FINISH,
    S_REJECT
  } state_e;

  // min(floor(gain*weight/256), 255)
  function automatic logic [CHW-1:0] addend(input logic [GAINW-1:0] gain,
                                            input logic [CHW-1:0] w);
    logic [GAINW+CHW-1:0] prod;
    logic [GAINW-1:0]     sh;
    prod = gain * w;
    sh   = prod[GAINW+CHW-1:CHW];
    return sh[GAINW-1] ? {CHW{1'b1}} : sh[CHW-1:0];
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/wals_div.sv
// wals_div: restoring unsigned divider, one quotient bit per cycle
// depends on wals_pkg for widths
`default_nettype none

module wals_div (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [wals_pkg::DVW-1:0] dividend_i,
  input  wire logic [wals_pkg::DSW-1:0] divisor_i,
  output logic                          done_o,
  output logic [wals_pkg::DVW-1:0]      quot_o,
  output logic                          rem_nz_o
);

  localparam int DVW  = wals_pkg::DVW;
  localparam int DSW  = wals_pkg::DSW;
  localparam int CNTW = $clog2(DVW + 1);

  logic            busy_q, done_q;
  logic [CNTW-1:0] cnt_q;
  logic [DVW-1:0]  quot_q, quot_d;
  logic [DSW-1:0]  rem_q, rem_d, dsr_q;
  logic [DSW:0]    rem_sh, dsr_ext, rem_sub;
  logic            ge;

  // one restoring step
  always_comb begin
    rem_sh  = {rem_q, quot_q[DVW-1]};
    dsr_ext = {1'b0, dsr_q};
    ge      = rem_sh >= dsr_ext;
    rem_sub = rem_sh - dsr_ext;
    rem_d   = ge ? rem_sub[DSW-1:0] : rem_sh[DSW-1:0];
    quot_d  = {quot_q[DVW-2:0], ge};
  end

  // sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNTW'(DVW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNTW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // operands
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      dsr_q  <= divisor_i;
    end else if (busy_q) begin
      quot_q <= quot_d;
      rem_q  <= rem_d;
    end
  end

  assign done_o   = done_q;
  assign quot_o   = quot_q;
  assign rem_nz_o = rem_q != '0;

endmodule

`default_nettype wire

>>> hw/rtl/wals_dp.sv
// wals_dp: clip, setup, search and stepping datapath with output register
// depends on wals_pkg and wals_div
`default_nettype none

module wals_dp #(
  parameter int SCREEN_WIDTH    = 320,
  parameter int SCREEN_HEIGHT   = 200,
  parameter int COORD_FRAC_BITS = 4
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire wals_pkg::cmd_t             cmd_i,
  output wals_pkg::stat_t                 stat_o,
  input  wire wals_pkg::in_t              in_data_i,
  input  wire logic                       out_stall_i,
  output logic                            out_valid_o,
  output wals_pkg::out_t                  out_data_o,
  input  wire logic                       cfg_valid_i,
  input  wire logic [wals_pkg::CIDXW-1:0] cfg_index_i,
  input  wire logic [wals_pkg::GAINW-1:0] cfg_data_i
);

  localparam int CW    = wals_pkg::CW;
  localparam int CW1   = CW + 1;
  localparam int QW    = CW + 2;
  localparam int PW    = 2 * CW1;
  localparam int DVW   = wals_pkg::DVW;
  localparam int DSW   = wals_pkg::DSW;
  localparam int YW    = wals_pkg::YW;
  localparam int FW    = wals_pkg::FW;
  localparam int F     = COORD_FRAC_BITS;
  localparam int VW    = YW - FW - F;
  localparam int EW    = F + 2;
  localparam int EMW   = EW + FW + 1;
  localparam int STEPW = wals_pkg::STEPW;
  localparam int GAINW = wals_pkg::GAINW;
  localparam int IDXW  = wals_pkg::IDXW;

  localparam logic signed [CW-1:0] LO   = CW'(1 << F);
  localparam logic signed [CW-1:0] HI_X = CW'((SCREEN_WIDTH - 2) << F);
  localparam logic signed [CW-1:0] HI_Y = CW'((SCREEN_HEIGHT - 2) << F);
  localparam logic [IDXW-1:0]      W16  = IDXW'(SCREEN_WIDTH);
  localparam logic [10:0]          VMAX_XMAJ = 11'(SCREEN_HEIGHT - 2);
  localparam logic [10:0]          VMAX_YMAJ = 11'(SCREEN_WIDTH - 2);

  function automatic logic signed [CW-1:0] clampc(input logic signed [CW-1:0] v,
                                                 input logic signed [CW-1:0] lo,
                                                 input logic signed [CW-1:0] hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // config
  logic [GAINW-1:0] gain_r_q, gain_g_q, gain_b_q;

  // clip state
  logic signed [CW-1:0]  x1_q, y1_q, x2_q, y2_q, nb1_q, nb2_q;
  logic signed [PW-1:0]  prod_q;
  logic signed [CW1-1:0] d_q;
  logic                  neg_q;

  // setup and search state
  logic signed [CW-1:0]  u1_q, u2_q, w1_q, ui_q;
  logic [CW-1:0]         majd_q, mind_q;
  logic [10:0]           vmax_q;
  logic signed [EW-1:0]  err_q;
  logic signed [YW-1:0]  ycor_q;
  logic [STEPW-1:0]      n_q;

  // line state
  logic                  line_active_q;
  logic [FW-1:0]         slope_q, frac_q;
  logic [IDXW-1:0]       pos_q, ms_q, ns_q;
  logic [STEPW-1:0]      steps_q;

  // output register
  logic                  out_valid_q;
  wals_pkg::out_t        out_q, out_d;
  logic                  out_load;

  // divider
  logic                  div_start, div_done, div_rem_nz;
  logic [DVW-1:0]        div_dividend, div_quot;
  logic [DSW-1:0]        div_divisor;

  // combinational terms
  logic signed [CW-1:0]  a1, a2, b1, b2, hi, n1, n2, nk;
  logic                  lt1, lt2, gt1, gt2;
  logic signed [CW1-1:0] diff, e, dd;
  logic signed [PW-1:0]  prod_d;
  logic [PW-1:0]         prod_mag;
  logic [CW1-1:0]        d_mag;
  logic signed [QW-1:0]  qs, newb, newb_c;
  logic signed [CW1-1:0] du, dv;
  logic                  sxp, syp, swap;
  logic signed [CW-1:0]  tx1, tx2, ty1, ty2;
  logic [CW1-1:0]        adu, adv;
  logic [IDXW-1:0]       msx, msy;
  logic signed [CW-1:0]  ui1, u2i, u1n, u2n;
  logic signed [EMW-1:0] em;
  logic signed [YW-1:0]  sinc;
  logic signed [VW-1:0]  v;
  logic [VW-1:0]         vabs;
  logic [IDXW-1:0]       pos_new;
  logic [7:0]            c, ci;
  logic [FW:0]           fsum;

  // clip check and interpolation terms
  always_comb begin
    a1  = cmd_i.axis_y ? y1_q : x1_q;
    a2  = cmd_i.axis_y ? y2_q : x2_q;
    b1  = cmd_i.axis_y ? x1_q : y1_q;
    b2  = cmd_i.axis_y ? x2_q : y2_q;
    hi  = cmd_i.axis_y ? HI_Y : HI_X;
    lt1 = a1 < LO;
    lt2 = a2 < LO;
    gt1 = a1 > hi;
    gt2 = a2 > hi;
    n1  = clampc(a1, LO, hi);
    n2  = clampc(a2, LO, hi);
    nk  = cmd_i.second ? n2 : n1;
    diff   = CW1'(nk) - CW1'(a1);
    e      = CW1'(b2) - CW1'(b1);
    dd     = CW1'(a2) - CW1'(a1);
    prod_d = PW'(diff) * PW'(e);
    prod_mag = prod_q[PW-1] ? PW'(-prod_q) : PW'(prod_q);
    d_mag    = d_q[CW1-1] ? CW1'(-d_q) : CW1'(d_q);
    // floor quotient and interpolated coordinate
    qs     = neg_q ? -(QW'(div_quot) + QW'(div_rem_nz)) : QW'(div_quot);
    newb   = QW'(b1) + qs;
    newb_c = newb;
    if (cmd_i.axis_y) begin
      if (newb < QW'(LO)) newb_c = QW'(LO);
      else if (newb > QW'(HI_X)) newb_c = QW'(HI_X);
    end
  end

  // orientation terms
  always_comb begin
    du   = CW1'(x2_q) - CW1'(x1_q);
    dv   = CW1'(y2_q) - CW1'(y1_q);
    sxp  = du > 0;
    syp  = dv > 0;
    tx1  = sxp ? x1_q : -x1_q;
    tx2  = sxp ? x2_q : -x2_q;
    ty1  = syp ? y1_q : -y1_q;
    ty2  = syp ? y2_q : -y2_q;
    adu  = du[CW1-1] ? CW1'(-du) : CW1'(du);
    adv  = dv[CW1-1] ? CW1'(-dv) : CW1'(dv);
    swap = adv > adu;
    msx  = sxp ? IDXW'(1) : {IDXW{1'b1}};
    msy  = syp ? W16 : IDXW'(-W16);
  end

  // start position terms
  always_comb begin
    u1n  = -u1_q;
    u2n  = -u2_q;
    ui1  = u1_q[CW-1] ? -(u1n >>> F) : (u1_q >>> F);
    u2i  = u2_q[CW-1] ? -(u2n >>> F) : (u2_q >>> F);
    em   = EMW'(err_q) * EMW'($signed({1'b0, slope_q}));
    sinc = YW'($signed({1'b0, slope_q})) <<< F;
    v    = ycor_q[YW-1:FW+F];
    vabs = v[VW-1] ? VW'(-v) : VW'(v);
    pos_new = IDXW'(ui_q) * ms_q + IDXW'(v) * ns_q;
  end

  // step terms
  always_comb begin
    c    = frac_q[FW-1:FW-8];
    ci   = ~c;
    fsum = {1'b0, frac_q} + {1'b0, slope_q};
  end

  // result item
  always_comb begin
    out_d    = '0;
    out_load = 1'b0;
    case (cmd_i.op)
      wals_pkg::CMD_STEP: begin
        out_load = 1'b1;
        if (!line_active_q) begin
          out_d.status = wals_pkg::STAT_IDLE;
        end else begin
          out_d.status     = wals_pkg::STAT_PAIR;
          out_d.near_index = pos_q;
          out_d.near_red   = wals_pkg::addend(gain_r_q, ci);
          out_d.near_green = wals_pkg::addend(gain_g_q, ci);
          out_d.near_blue  = wals_pkg::addend(gain_b_q, ci);
          out_d.far_index  = pos_q + ns_q;
          out_d.far_red    = wals_pkg::addend(gain_r_q, c);
          out_d.far_green  = wals_pkg::addend(gain_g_q, c);
          out_d.far_blue   = wals_pkg::addend(gain_b_q, c);
          out_d.last_pair  = steps_q == '0;
        end
      end
      wals_pkg::CMD_FINISH: begin
        out_load     = 1'b1;
        out_d.status = wals_pkg::STAT_ACCEPTED;
      end
      wals_pkg::CMD_REJECT: begin
        out_load     = 1'b1;
        out_d.status = wals_pkg::STAT_REJECTED;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  // divider operands
  assign div_start    = (cmd_i.op == wals_pkg::CMD_DIV_CLIP) ||
                        (cmd_i.op == wals_pkg::CMD_DIV_SLOPE);
  assign div_dividend = (cmd_i.op == wals_pkg::CMD_DIV_SLOPE) ?
                        DVW'({mind_q, {FW{1'b0}}}) : DVW'(prod_mag);
  assign div_divisor  = (cmd_i.op == wals_pkg::CMD_DIV_SLOPE) ?
                        DSW'(majd_q) : DSW'(d_mag);

  wals_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_nz_o   (div_rem_nz)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_r_q      <= wals_pkg::GAIN_RESET;
      gain_g_q      <= wals_pkg::GAIN_RESET;
      gain_b_q      <= wals_pkg::GAIN_RESET;
      line_active_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          wals_pkg::REG_GAIN_RED:   gain_r_q <= cfg_data_i;
          wals_pkg::REG_GAIN_GREEN: gain_g_q <= cfg_data_i;
          wals_pkg::REG_GAIN_BLUE:  gain_b_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.op == wals_pkg::CMD_LOAD) begin
        line_active_q <= 1'b0;
      end else if (cmd_i.op == wals_pkg::CMD_FINISH) begin
        line_active_q <= 1'b1;
      end else if (cmd_i.op == wals_pkg::CMD_STEP && steps_q == '0) begin
        line_active_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (out_load) out_q <= out_d;
    case (cmd_i.op)
      wals_pkg::CMD_LOAD: begin
        x1_q <= CW'(in_data_i.x_start);
        y1_q <= CW'(in_data_i.y_start);
        x2_q <= CW'(in_data_i.x_end);
        y2_q <= CW'(in_data_i.y_end);
      end
      wals_pkg::CMD_CLIP_MUL: begin
        prod_q <= prod_d;
        d_q    <= dd;
      end
      wals_pkg::CMD_DIV_CLIP: begin
        neg_q <= prod_q[PW-1] ^ d_q[CW1-1];
      end
      wals_pkg::CMD_CLIP_STORE: begin
        if (cmd_i.second) nb2_q <= CW'(newb_c);
        else nb1_q <= CW'(newb_c);
      end
      wals_pkg::CMD_CLIP_APPLY: begin
        if (cmd_i.axis_y) begin
          y1_q <= n1;
          y2_q <= n2;
          x1_q <= nb1_q;
          x2_q <= nb2_q;
        end else begin
          x1_q <= n1;
          x2_q <= n2;
          y1_q <= nb1_q;
          y2_q <= nb2_q;
        end
      end
      wals_pkg::CMD_ORIENT: begin
        u1_q   <= swap ? ty1 : tx1;
        u2_q   <= swap ? ty2 : tx2;
        w1_q   <= swap ? tx1 : ty1;
        majd_q <= swap ? CW'(adv) : CW'(adu);
        mind_q <= swap ? CW'(adu) : CW'(adv);
        ms_q   <= swap ? msy : msx;
        ns_q   <= swap ? msx : msy;
        vmax_q <= swap ? VMAX_YMAJ : VMAX_XMAJ;
      end
      wals_pkg::CMD_SLOPE_ZERO: begin
        slope_q <= '0;
      end
      wals_pkg::CMD_SLOPE_STORE: begin
        slope_q <= (|div_quot[DVW-1:FW]) ? {FW{1'b1}} : div_quot[FW-1:0];
      end
      wals_pkg::CMD_INIT: begin
        ui_q  <= ui1;
        n_q   <= STEPW'(u2i - ui1);
        err_q <= EW'((ui1 <<< F) - u1_q);
      end
      wals_pkg::CMD_YMUL: begin
        ycor_q <= (YW'(w1_q) <<< FW) + YW'(em);
      end
      wals_pkg::CMD_SEARCH_STEP: begin
        ycor_q <= ycor_q + sinc;
        ui_q   <= ui_q + CW'(1);
        n_q    <= n_q - 1'b1;
      end
      wals_pkg::CMD_FINISH: begin
        frac_q  <= ycor_q[FW+F-1:F];
        pos_q   <= pos_new;
        steps_q <= n_q;
      end
      wals_pkg::CMD_STEP: begin
        if (line_active_q && steps_q != '0) begin
          steps_q <= steps_q - 1'b1;
          frac_q  <= fsum[FW-1:0];
          pos_q   <= pos_q + ms_q + (fsum[FW] ? ns_q : '0);
        end
      end
      default: ;
    endcase
  end

  // status to controller
  always_comb begin
    stat_o.reject      = (lt1 && lt2) || (gt1 && gt2);
    stat_o.clip_needed = lt1 || lt2 || gt1 || gt2;
    stat_o.div_done    = div_done;
    stat_o.du_zero     = majd_q == '0;
    stat_o.visible     = (vabs != '0) && (vabs <= VW'(vmax_q));
    stat_o.n_zero      = n_q == '0;
    stat_o.out_free    = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

>>> hw/rtl/wals_ctrl.sv
// wals_ctrl: sequencer for line setup and step items
// depends on wals_pkg; drives wals_dp through command and status structs
`default_nettype none

module wals_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic            in_op_i,
  output logic                 in_stall_o,
  output wals_pkg::cmd_t       cmd_o,
  input  wire wals_pkg::stat_t stat_i
);

  wals_pkg::state_e state_q, state_d;
  logic             axis_y_q, axis_y_d, second_q, second_d;
  logic             accept;

  assign in_stall_o = !(state_q == wals_pkg::S_IDLE && stat_i.out_free);
  assign accept     = in_valid_i && !in_stall_o;

  // next state
  always_comb begin
    state_d  = state_q;
    axis_y_d = axis_y_q;
    second_d = second_q;
    case (state_q)
      wals_pkg::S_IDLE: begin
        if (accept && in_op_i == wals_pkg::OP_START) begin
          state_d  = wals_pkg::S_CHECK;
          axis_y_d = 1'b0;
          second_d = 1'b0;
        end
      end
      wals_pkg::S_CHECK: begin
        if (stat_i.reject) begin
          state_d = wals_pkg::S_REJECT;
        end else if (stat_i.clip_needed) begin
          state_d  = wals_pkg::S_MUL;
          second_d = 1'b0;
        end else if (axis_y_q) begin
          state_d = wals_pkg::S_ORIENT;
        end else begin
          axis_y_d = 1'b1;
        end
      end
      wals_pkg::S_MUL:      state_d = wals_pkg::S_DIV_GO;
      wals_pkg::S_DIV_GO:   state_d = wals_pkg::S_DIV_WAIT;
      wals_pkg::S_DIV_WAIT: begin
        if (stat_i.div_done) state_d = wals_pkg::S_STORE;
      end
      wals_pkg::S_STORE: begin
        if (second_q) begin
          state_d = wals_pkg::S_APPLY;
        end else begin
          second_d = 1'b1;
          state_d  = wals_pkg::S_MUL;
        end
      end
      wals_pkg::S_APPLY: begin
        if (axis_y_q) begin
          state_d = wals_pkg::S_ORIENT;
        end else begin
          axis_y_d = 1'b1;
          second_d = 1'b0;
          state_d  = wals_pkg::S_CHECK;
        end
      end
      wals_pkg::S_ORIENT:   state_d = wals_pkg::S_SLOPE_GO;
      wals_pkg::S_SLOPE_GO: begin
        state_d = stat_i.du_zero ? wals_pkg::S_INIT : wals_pkg::S_SLOPE_WAIT;
      end
      wals_pkg::S_SLOPE_WAIT: begin
        if (stat_i.div_done) state_d = wals_pkg::S_SLOPE_STORE;
      end
      wals_pkg::S_SLOPE_STORE: state_d = wals_pkg::S_INIT;
      wals_pkg::S_INIT:        state_d = wals_pkg::S_YMUL;
      wals_pkg::S_YMUL:        state_d = wals_pkg::S_SEARCH;
      wals_pkg::S_SEARCH: begin
        if (stat_i.visible) state_d = wals_pkg::S_FINISH;
        else if (stat_i.n_zero) state_d = wals_pkg::S_REJECT;
      end
      wals_pkg::S_FINISH: state_d = wals_pkg::S_IDLE;
      wals_pkg::S_REJECT: state_d = wals_pkg::S_IDLE;
      default:            state_d = wals_pkg::S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o.op     = wals_pkg::CMD_NONE;
    cmd_o.axis_y = axis_y_q;
    cmd_o.second = second_q;
    case (state_q)
      wals_pkg::S_IDLE: begin
        if (accept) begin
          cmd_o.op = (in_op_i == wals_pkg::OP_START) ? wals_pkg::CMD_LOAD
                                                      : wals_pkg::CMD_STEP;
        end
      end
      wals_pkg::S_MUL:    cmd_o.op = wals_pkg::CMD_CLIP_MUL;
      wals_pkg::S_DIV_GO: cmd_o.op = wals_pkg::CMD_DIV_CLIP;
      wals_pkg::S_STORE:  cmd_o.op = wals_pkg::CMD_CLIP_STORE;
      wals_pkg::S_APPLY:  cmd_o.op = wals_pkg::CMD_CLIP_APPLY;
      wals_pkg::S_ORIENT: cmd_o.op = wals_pkg::CMD_ORIENT;
      wals_pkg::S_SLOPE_GO: begin
        cmd_o.op = stat_i.du_zero ? wals_pkg::CMD_SLOPE_ZERO : wals_pkg::CMD_DIV_SLOPE;
      end
      wals_pkg::S_SLOPE_STORE: cmd_o.op = wals_pkg::CMD_SLOPE_STORE;
      wals_pkg::S_INIT:        cmd_o.op = wals_pkg::CMD_INIT;
      wals_pkg::S_YMUL:        cmd_o.op = wals_pkg::CMD_YMUL;
      wals_pkg::S_SEARCH: begin
        if (!stat_i.visible && !stat_i.n_zero) cmd_o.op = wals_pkg::CMD_SEARCH_STEP;
      end
      wals_pkg::S_FINISH: cmd_o.op = wals_pkg::CMD_FINISH;
      wals_pkg::S_REJECT: cmd_o.op = wals_pkg::CMD_REJECT;
      default:            cmd_o.op = wals_pkg::CMD_NONE;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= wals_pkg::S_IDLE;
      axis_y_q <= 1'b0;
      second_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      axis_y_q <= axis_y_d;
      second_q <= second_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/wu_antialiased_line_stepper_unit.sv
// Antialiased line stepper. A step item (op 1) is answered by one registered
// result at the next clock edge, and a new step item is taken every cycle
// while the result side keeps up, so stepping runs at one pixel pair per
// clock. A start item (op 0) runs a setup sequence on one bit-serial divider:
// each clip axis that needs clipping costs two divisions, the slope costs one
// more unless the major delta is zero, and the search for the first visible
// major step then tries one step after another, so a start is shortest for a
// line wholly beyond one screen edge and grows with any invisible leading run.
// Gains are to be written through the config port only while the block is
// idle; the block itself does not enforce it.
// top level: wals_ctrl and wals_dp, types from wals_pkg
`default_nettype none

module wu_antialiased_line_stepper_unit #(
  parameter int SCREEN_WIDTH    = 320,
  parameter int SCREEN_HEIGHT   = 200,
  parameter int COORD_FRAC_BITS = 4
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire wals_pkg::in_t              in_data_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output wals_pkg::out_t                  out_data_o,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [wals_pkg::CIDXW-1:0] cfg_index_i,
  input  wire logic [wals_pkg::GAINW-1:0] cfg_data_i
);

  wals_pkg::cmd_t  cmd;
  wals_pkg::stat_t stat;

  // gains are plain registers, always writable
  assign cfg_ready_o = 1'b1;

  // sequencer
  wals_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_op_i    (in_data_i.op),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  // datapath
  wals_dp #(
    .SCREEN_WIDTH    (SCREEN_WIDTH),
    .SCREEN_HEIGHT   (SCREEN_HEIGHT),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

endmodule

`default_nettype wire

>>> hw/rtl/wals_checker.sv
// wals_checker: port-level checks of the line stepper, bound to the top level
// depends on wals_pkg
`default_nettype none

module wals_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_valid_i,
  input wire logic           in_stall_o,
  input wire wals_pkg::in_t  in_data_i,
  input wire logic           out_valid_o,
  input wire logic           out_stall_i,
  input wire wals_pkg::out_t out_data_o
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // only pixel pairs carry indices and the last flag
  a_non_pair_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != wals_pkg::STAT_PAIR |->
      out_data_o.near_index == '0 && out_data_o.far_index == '0 &&
      out_data_o.last_pair == 1'b0)
    else $error("non-pair result with payload");

  // a step transaction is answered on the next cycle
  a_step_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.op == wals_pkg::OP_STEP |=> out_valid_o)
    else $error("step without result");

  // input is taken only when the result slot frees up
  a_take_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !out_valid_o || !out_stall_i)
    else $error("input taken with result slot blocked");

endmodule

bind wu_antialiased_line_stepper_unit wals_checker u_wals_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

>>> dv/wals_line_checker.sv
// wals_line_checker: watches the input, result and gain-write channels of the
// antialiased line stepper, predicts every result and compares field by field
// depends on wals_pkg for the transaction types and codes
`timescale 1ns / 1ps

module wals_line_checker #(
  parameter int SCREEN_WIDTH    = 320,
  parameter int SCREEN_HEIGHT   = 200,
  parameter int COORD_FRAC_BITS = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  wals_pkg::in_t                  in_data_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  wals_pkg::out_t                 out_data_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [wals_pkg::CIDXW-1:0]     cfg_index_i,
  input  logic [wals_pkg::GAINW-1:0]     cfg_data_i,
  output int                             fail_count_o,
  output int                             pending_o
);

  // predicted gains and stepper state
  logic [wals_pkg::GAINW-1:0] gain_r, gain_g, gain_b;
  logic             drawing;
  logic [31:0]      frac_acc;
  logic [31:0]      slope_acc;
  logic [15:0]      pix_pos;
  logic [15:0]      major_step;
  logic [15:0]      minor_step;
  logic [10:0]      pairs_left;

  wals_pkg::out_t pair_q[$];

  function automatic longint floor_div(longint n, longint d);
    longint q, r;
    if (d == 0) return 0;
    q = n / d;
    r = n % d;
    if (r != 0 && ((r < 0) != (d < 0))) q--;
    return q;
  endfunction

  function automatic longint clip_to(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic [wals_pkg::CHW-1:0] scale_weight(
      logic [wals_pkg::GAINW-1:0] g, logic [7:0] w);
    logic [16:0] prod;
    prod = g * w;
    return (prod >> 8) > 255 ? 8'd255 : prod[15:8];
  endfunction

  // line setup: clip, orient, slope, first visible step
  function automatic logic [1:0] setup_line(wals_pkg::in_t it);
    longint one, lox, hix, loy, hiy;
    longint x1, y1, x2, y2, du, dv, ms, ns, t, msize, ui, u2i, n, v, den;
    longint n1, n2, d, e, ox, oy, s, err, ycor;
    logic [31:0] slope, frac;
    bit a1, a2, b1, b2;
    one = longint'(1) << COORD_FRAC_BITS;
    lox = one; hix = (SCREEN_WIDTH - 2) * one;
    loy = one; hiy = (SCREEN_HEIGHT - 2) * one;
    x1 = it.x_start; y1 = it.y_start; x2 = it.x_end; y2 = it.y_end;
    v = 0; slope = 0; frac = 0;
    drawing = 1'b0;
    a1 = x1 < lox; a2 = x2 < lox; b1 = x1 > hix; b2 = x2 > hix;
    if ((a1 && a2) || (b1 && b2)) return wals_pkg::STAT_REJECTED;
    if (a1 || a2 || b1 || b2) begin
      n1 = clip_to(x1, lox, hix); n2 = clip_to(x2, lox, hix);
      d = x2 - x1; e = y2 - y1;
      if (d == 0) d = 1;
      oy = y1;
      y1 = oy + floor_div((n1 - x1) * e, d);
      y2 = oy + floor_div((n2 - x1) * e, d);
      x1 = n1; x2 = n2;
    end
    a1 = y1 < loy; a2 = y2 < loy; b1 = y1 > hiy; b2 = y2 > hiy;
    if ((a1 && a2) || (b1 && b2)) return wals_pkg::STAT_REJECTED;
    if (a1 || a2 || b1 || b2) begin
      n1 = clip_to(y1, loy, hiy); n2 = clip_to(y2, loy, hiy);
      d = y2 - y1; e = x2 - x1;
      ox = x1; oy = y1;
      if (d == 0) d = 1;
      x1 = clip_to(ox + floor_div((n1 - oy) * e, d), lox, hix);
      x2 = clip_to(ox + floor_div((n2 - oy) * e, d), lox, hix);
      y1 = n1; y2 = n2;
    end
    // orientation and major axis
    du = x2 - x1; dv = y2 - y1;
    if (du > 0) ms = 1;
    else begin
      ms = -1; x1 = -x1; x2 = -x2;
    end
    if (dv > 0) ns = SCREEN_WIDTH;
    else begin
      ns = -SCREEN_WIDTH; y1 = -y1; y2 = -y2;
    end
    du = mag(du); dv = mag(dv);
    msize = SCREEN_HEIGHT;
    if (dv > du) begin
      t = du; du = dv; dv = t;
      t = ms; ms = ns; ns = t;
      t = x1; x1 = y1; y1 = t;
      t = x2; x2 = y2; y2 = t;
      msize = SCREEN_WIDTH;
    end
    if (du != 0) begin
      s = (dv <<< 32) / du;
      slope = s > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : s[31:0];
    end
    // search for the first visible major step
    ui = x1 / one;
    u2i = x2 / one;
    n = mag(u2i - ui);
    den = longint'(1) << (COORD_FRAC_BITS + 32);
    while (n >= 0) begin
      err = ui * one - x1;
      ycor = (y1 <<< 32) + err * longint'({1'b0, slope});
      v = floor_div(ycor, den);
      t = (ycor - v * den) >> COORD_FRAC_BITS;
      frac = t[31:0];
      if (mag(v) >= 1 && mag(v) <= msize - 2) break;
      ui++;
      n--;
    end
    if (n < 0) return wals_pkg::STAT_REJECTED;
    t = ui * ms + v * ns;
    drawing    = 1'b1;
    frac_acc   = frac;
    slope_acc  = slope;
    pix_pos    = t[15:0];
    major_step = ms[15:0];
    minor_step = ns[15:0];
    pairs_left = n[10:0];
    return wals_pkg::STAT_ACCEPTED;
  endfunction

  function automatic wals_pkg::out_t predict_pair(wals_pkg::in_t it);
    wals_pkg::out_t r;
    logic [7:0]  c;
    logic [31:0] prev;
    r = '0;
    if (it.op == wals_pkg::OP_START) begin
      r.status = setup_line(it);
      return r;
    end
    if (!drawing) begin
      r.status = wals_pkg::STAT_IDLE;
      return r;
    end
    c = frac_acc[31:24];
    r.status     = wals_pkg::STAT_PAIR;
    r.near_index = pix_pos;
    r.near_red   = scale_weight(gain_r, 8'd255 - c);
    r.near_green = scale_weight(gain_g, 8'd255 - c);
    r.near_blue  = scale_weight(gain_b, 8'd255 - c);
    r.far_index  = pix_pos + minor_step;
    r.far_red    = scale_weight(gain_r, c);
    r.far_green  = scale_weight(gain_g, c);
    r.far_blue   = scale_weight(gain_b, c);
    if (pairs_left == 0) begin
      r.last_pair = 1'b1;
      drawing = 1'b0;
    end else begin
      pairs_left = pairs_left - 1;
      pix_pos = pix_pos + major_step;
      prev = frac_acc;
      frac_acc = frac_acc + slope_acc;
      if (frac_acc < prev) pix_pos = pix_pos + minor_step;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: %s got %0d expected %0d", $time, what, got, want);
    fail_count_o++;
  endtask

  task automatic compare_pair(wals_pkg::out_t got, wals_pkg::out_t want);
    if (got.status != want.status) report_mismatch("status", got.status, want.status);
    if (got.near_index != want.near_index)
      report_mismatch("near_index", got.near_index, want.near_index);
    if (got.near_red != want.near_red) report_mismatch("near_red", got.near_red, want.near_red);
    if (got.near_green != want.near_green)
      report_mismatch("near_green", got.near_green, want.near_green);
    if (got.near_blue != want.near_blue)
      report_mismatch("near_blue", got.near_blue, want.near_blue);
    if (got.far_index != want.far_index)
      report_mismatch("far_index", got.far_index, want.far_index);
    if (got.far_red != want.far_red) report_mismatch("far_red", got.far_red, want.far_red);
    if (got.far_green != want.far_green)
      report_mismatch("far_green", got.far_green, want.far_green);
    if (got.far_blue != want.far_blue) report_mismatch("far_blue", got.far_blue, want.far_blue);
    if (got.last_pair != want.last_pair)
      report_mismatch("last_pair", got.last_pair, want.last_pair);
  endtask

  // watch all channels, results first since a result never belongs to this edge's input
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_r = wals_pkg::GAIN_RESET; gain_g = wals_pkg::GAIN_RESET;
      gain_b = wals_pkg::GAIN_RESET;
      drawing = 1'b0; frac_acc = '0; slope_acc = '0; pix_pos = '0;
      major_step = '0; minor_step = '0; pairs_left = '0;
      pair_q.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (pair_q.size() == 0) report_mismatch("unexpected transaction", 1, 0);
        else compare_pair(out_data_i, pair_q.pop_front());
      end
      if (in_valid_i && !in_stall_i) pair_q.push_back(predict_pair(in_data_i));
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          wals_pkg::REG_GAIN_RED:   gain_r = cfg_data_i;
          wals_pkg::REG_GAIN_GREEN: gain_g = cfg_data_i;
          wals_pkg::REG_GAIN_BLUE:  gain_b = cfg_data_i;
          default: ;
        endcase
      end
      pending_o = pair_q.size();
    end
  end

endmodule

>>> dv/tb_wu_antialiased_line_stepper_unit.sv
// tb_wu_antialiased_line_stepper_unit: stimulus and verdict for the line stepper
// depends on wals_pkg, wu_antialiased_line_stepper_unit and wals_line_checker
`timescale 1ns / 1ps

module tb_wu_antialiased_line_stepper_unit;

  localparam int IDLE_LIMIT = 20000;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  wals_pkg::in_t    in_data;
  logic             out_valid;
  logic             out_stall;
  wals_pkg::out_t   out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [wals_pkg::CIDXW-1:0] cfg_index;
  logic [wals_pkg::GAINW-1:0] cfg_data;
  int               fail_count;
  int               pending;
  int               send_gap_pct;
  int               recv_stall_pct;
  int               hold_req;
  int               hold_seen;
  int               hold_left;
  int               quiet_cycles;

  wu_antialiased_line_stepper_unit u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  wals_line_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    send_gap_pct = 0;
    recv_stall_pct = 0;
    hold_req = 0;
    hold_seen = 0;
    hold_left = 0;
    quiet_cycles = 0;
  end

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // result side stall, with a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog on cycles with no transaction on any channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_item(wals_pkg::in_t it);
    bit taken;
    int gap;
    if ($urandom_range(99) < send_gap_pct) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // a start may still be setting up after the last result
    repeat (20) @(posedge clk);
  endtask

  task automatic write_gain(logic [wals_pkg::CIDXW-1:0] idx,
                            logic [wals_pkg::GAINW-1:0] val);
    bit taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic wals_pkg::in_t line_item(int x1, int y1, int x2, int y2);
    wals_pkg::in_t it;
    it.op = wals_pkg::OP_START;
    it.x_start = x1[15:0]; it.y_start = y1[15:0];
    it.x_end = x2[15:0];   it.y_end = y2[15:0];
    return it;
  endfunction

  function automatic wals_pkg::in_t step_item();
    wals_pkg::in_t it;
    it = {$urandom(), $urandom(), $urandom()};
    it.op = wals_pkg::OP_STEP;
    return it;
  endfunction

  task automatic send_steps(int count);
    for (int i = 0; i < count; i++) send_item(step_item());
  endtask

  // one line with random content, mostly on screen and short
  task automatic random_line(ref int sent);
    int x1, y1, x2, y2, span, steps, pick;
    pick = $urandom_range(99);
    if (pick < 12) begin
      x1 = $urandom(); y1 = $urandom(); x2 = $urandom(); y2 = $urandom();
      steps = $urandom_range(0, 6);
    end else begin
      span = (pick < 17) ? 5200 : $urandom_range(8, 640);
      x1 = $urandom_range(0, 5280) - 80;
      y1 = $urandom_range(0, 3280) - 80;
      x2 = x1 + $urandom_range(0, 2 * span) - span;
      y2 = y1 + $urandom_range(0, 2 * span) - span;
      steps = (pick < 17) ? 330 : $urandom_range(0, span / 16 + 4);
    end
    send_item(line_item(x1, y1, x2, y2));
    send_steps(steps);
    sent += steps + 1;
  endtask

  task automatic gain_setting(int r, int g, int b);
    write_gain(wals_pkg::REG_GAIN_RED, r);
    write_gain(wals_pkg::REG_GAIN_GREEN, g);
    write_gain(wals_pkg::REG_GAIN_BLUE, b);
  endtask

  initial begin
    int sent;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: idle steps, rejects, clipping, axes, extremes, abandon
    send_steps(2);
    send_item(line_item(-32768, 800, -32768, 1600));
    send_item(line_item(32767, 800, 32767, 1600));
    send_item(line_item(800, -32768, 1600, -32768));
    send_item(line_item(800, 32767, 1600, 32767));
    send_item(line_item(-32768, -32768, 32767, 32767));
    send_steps(3);
    send_item(line_item(-200, 100, 600, 900));
    send_steps(4);
    send_item(line_item(800, -40, 860, 3400));
    send_steps(3);
    send_item(line_item(800, 800, 800, 900));
    send_steps(8);
    send_item(line_item(800, 800, 900, 800));
    send_steps(8);
    send_item(line_item(805, 805, 805, 805));
    send_steps(2);
    send_item(line_item(16, 17, 16, 18));
    send_item(line_item(32767, -32768, -32768, 32767));
    send_steps(2);
    drain();

    // gains above 1.0 saturate
    gain_setting(511, 0, 300);
    send_item(line_item(100, 100, 300, 160));
    send_steps(14);
    drain();

    // phase one: sender rarely idles, receiver mostly stalls
    gain_setting(256, 128, 0);
    send_gap_pct = 9; recv_stall_pct = 86;
    sent = 0;
    while (sent < 300) random_line(sent);
    drain();

    // phase two: roles swapped, with one long hold-off on the result side
    gain_setting(0, 256, 77);
    send_gap_pct = 86; recv_stall_pct = 9;
    sent = 0;
    while (sent < 150) random_line(sent);
    send_gap_pct = 0;
    hold_req++;
    send_item(line_item(50, 50, 4000, 700));
    send_steps(60);
    sent += 61;
    send_gap_pct = 86;
    while (sent < 300) random_line(sent);
    drain();

    // phase three: no idling, with a pause until all results are in
    gain_setting($urandom_range(0, 256), $urandom_range(0, 511), 256);
    send_gap_pct = 0; recv_stall_pct = 0;
    sent = 0;
    while (sent < 150) random_line(sent);
    drain();
    while (sent < 300) random_line(sent);
    drain();

    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/wals_pkg.sv
hw/rtl/wals_div.sv
hw/rtl/wals_dp.sv
hw/rtl/wals_ctrl.sv
hw/rtl/wu_antialiased_line_stepper_unit.sv
hw/rtl/wals_checker.sv
dv/wals_line_checker.sv
dv/tb_wu_antialiased_line_stepper_unit.sv
